[rtl/cpp_pkg.sv]
// Package with payload types, control structs and constants for the polyline nearest-point block.
package cpp_pkg;

   localparam int SegBits  = 16;
   localparam int FracBits = 16;
   localparam int UBits    = FracBits + 1;

   // Shared multiply-accumulate unit: 34-bit signed operands, 68-bit result.
   localparam int MacOpW  = 34;
   localparam int MacAccW = 68;

   // Shared shift-subtract unit for square roots and divisions.
   localparam int IterRemW = 68;
   localparam int IterNumW = 98;
   localparam int IterDivW = 66;
   localparam int IterQW   = 49;
   localparam int IterCntW = 6;

   localparam logic [UBits-1:0] U_ONE    = UBits'(1) << FracBits;
   localparam logic [31:0]      DIST_INF = 32'hFFFF_FFFF;

   // Configuration register indexes.
   localparam logic [0:0] CSR_QUERY_X = 1'b0;
   localparam logic [0:0] CSR_QUERY_Y = 1'b1;

   typedef struct packed {
      logic signed [31:0]  pos_x;
      logic signed [31:0]  pos_y;
      logic [SegBits-1:0]  seg_index;
      logic [UBits-1:0]    seg_param;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [SegBits-1:0]  best_segment;
      logic [UBits-1:0]    best_u1;
      logic [UBits-1:0]    best_u2;
      logic [UBits-1:0]    best_t;
      logic                is_lerped;
      logic signed [31:0]  near_x;
      logic signed [31:0]  near_y;
      logic [31:0]         near_dist;
   } rsp_type;

   // Best location found so far.
   typedef struct packed {
      logic [SegBits-1:0]  seg;
      logic [UBits-1:0]    u1;
      logic [UBits-1:0]    u2;
      logic [UBits-1:0]    t;
      logic                lerp;
      logic [31:0]         x;
      logic [31:0]         y;
   } rec_type;

   typedef struct packed {
      logic                      start;
      logic                      sub;
      logic signed [MacOpW-1:0]  a1;
      logic signed [MacOpW-1:0]  b1;
      logic signed [MacOpW-1:0]  a2;
      logic signed [MacOpW-1:0]  b2;
   } mac_ctl_type;

   typedef struct packed {
      logic                  start;
      logic                  mode_sqrt;
      logic [IterCntW-1:0]   steps;
      logic [IterRemW-1:0]   rem_init;
      logic [IterNumW-1:0]   num_init;
      logic [IterDivW-1:0]   divisor;
   } iter_ctl_type;

endpackage

[rtl/cpp_mac.sv]
// Shared multiply-accumulate unit computing a1*b1 plus or minus a2*b2.
module cpp_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cpp_pkg::mac_ctl_type                  ctl,
   output logic signed [cpp_pkg::MacAccW-1:0]    acc,
   output logic                                  done
);
   import cpp_pkg::*;

   logic [1:0]                phase_ff, phase_in;
   logic                      done_ff, done_in;
   mac_ctl_type               op_ff, op_in;
   logic signed [MacAccW-1:0] prod_ff, prod_in;
   logic signed [MacAccW-1:0] acc_ff, acc_in;

   // Sequence: latch operands, first product, second product, accumulate.
   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      case (phase_ff)
         2'd0: begin
            if (ctl.start) begin
               op_in    = ctl;
               phase_in = 2'd1;
            end
         end
         2'd1: begin
            prod_in  = op_ff.a1 * op_ff.b1;
            phase_in = 2'd2;
         end
         2'd2: begin
            acc_in   = prod_ff;
            prod_in  = op_ff.a2 * op_ff.b2;
            phase_in = 2'd3;
         end
         2'd3: begin
            acc_in   = op_ff.sub ? (acc_ff - prod_ff) : (acc_ff + prod_ff);
            done_in  = 1'b1;
            phase_in = 2'd0;
         end
         default: begin
            phase_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      op_ff   <= op_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

[rtl/cpp_iter.sv]
// Shared bit-serial unit for restoring square root and restoring division.
module cpp_iter (
   input  logic                              clock,
   input  logic                              reset,
   input  cpp_pkg::iter_ctl_type             ctl,
   output logic [cpp_pkg::IterQW-1:0]        result,
   output logic                              done
);
   import cpp_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  sqrt_ff, sqrt_in;
   logic [IterCntW-1:0]   cnt_ff, cnt_in;
   logic [IterRemW-1:0]   rem_ff, rem_in;
   logic [IterNumW-1:0]   num_ff, num_in;
   logic [IterDivW-1:0]   div_ff, div_in;
   logic [IterQW-1:0]     q_ff, q_in;
   logic [IterRemW-1:0]   rem_sh;
   logic [IterRemW-1:0]   trial;
   logic                  fits;

   // One step: bring in the next numerator bits and subtract the trial value if it fits.
   always_comb begin
      if (sqrt_ff) begin
         rem_sh = {rem_ff[IterRemW-3:0], num_ff[IterNumW-1 -: 2]};
         trial  = {{(IterRemW-IterQW-2){1'b0}}, q_ff, 2'b01};
      end else begin
         rem_sh = {rem_ff[IterRemW-2:0], num_ff[IterNumW-1]};
         trial  = {{(IterRemW-IterDivW){1'b0}}, div_ff};
      end
      fits = (rem_sh >= trial);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      q_in    = q_ff;
      if (busy_ff) begin
         rem_in = fits ? (rem_sh - trial) : rem_sh;
         q_in   = {q_ff[IterQW-2:0], fits};
         num_in = sqrt_ff ? (num_ff << 2) : (num_ff << 1);
         cnt_in = cnt_ff - IterCntW'(1);
         if (cnt_ff == IterCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctl.start) begin
         busy_in = 1'b1;
         sqrt_in = ctl.mode_sqrt;
         cnt_in  = ctl.steps;
         rem_in  = ctl.rem_init;
         num_in  = ctl.num_init;
         div_in  = ctl.divisor;
         q_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sqrt_ff <= sqrt_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      div_ff  <= div_in;
      q_ff    <= q_in;
   end

   assign result = q_ff;
   assign done   = done_ff;

endmodule

[rtl/closest_point_on_polyline.sv]
// Top level: sequencer that finds the nearest location on a streamed polyline to a query point.
//
// Each request transaction carries one polyline sample; the block holds it for the
// whole computation and stalls the request side meanwhile. A sample with no held
// predecessor, or one after an exact hit, is not scored against a span. A sample that
// closes a pair stops early on an exact hit at the first sample or on a span of zero
// length. A projection beyond the span is passed over, one before the span scores the
// distance to the first sample, and one inside the span computes the distance to the line
// and takes it with the lerp when it wins and the indices pair. A sample marked last adds the
// final-point test, unless after an exact hit, and waits while an earlier response
// still sits in the output register. The work is shared between one bit-serial unit
// that computes the square roots (33 or 49 steps) and divisions (32 or 17 steps) in
// turn, and one multiply-accumulate unit for the squared lengths, dot and cross products
// and the lerp. One response transaction leaves at the sample marked last; the next
// sample may be accepted while that response waits to be taken.
module closest_point_on_polyline (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cpp_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output cpp_pkg::rsp_type   rsp_data,
   input  logic               csr_wr_en,
   input  logic [0:0]         csr_index,
   input  logic [31:0]        csr_wr_data
);
   import cpp_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_DIFF = 5'd1;
   localparam logic [4:0] S_HIT  = 5'd2;
   localparam logic [4:0] S_LEN  = 5'd3;
   localparam logic [4:0] S_DOT  = 5'd4;
   localparam logic [4:0] S_PSM  = 5'd5;
   localparam logic [4:0] S_PSQ  = 5'd6;
   localparam logic [4:0] S_CR   = 5'd7;
   localparam logic [4:0] S_DEN  = 5'd8;
   localparam logic [4:0] S_SAT  = 5'd9;
   localparam logic [4:0] S_DPD  = 5'd10;
   localparam logic [4:0] S_CMP  = 5'd11;
   localparam logic [4:0] S_TDV  = 5'd12;
   localparam logic [4:0] S_LX   = 5'd13;
   localparam logic [4:0] S_LY   = 5'd14;
   localparam logic [4:0] S_UPD  = 5'd15;
   localparam logic [4:0] S_FDIF = 5'd16;
   localparam logic [4:0] S_FMAC = 5'd17;
   localparam logic [4:0] S_FPSM = 5'd18;
   localparam logic [4:0] S_FPSQ = 5'd19;
   localparam logic [4:0] S_EMIT = 5'd20;

   localparam logic [IterCntW-1:0] PT_STEPS  = IterCntW'(33);
   localparam logic [IterCntW-1:0] DEN_STEPS = IterCntW'(49);
   localparam logic [IterCntW-1:0] DP_STEPS  = IterCntW'(32);
   localparam logic [IterCntW-1:0] T_STEPS   = IterCntW'(UBits);

   logic [4:0]          state_ff, state_in;
   logic [31:0]         query_x_ff, query_y_ff;
   req_type             cur_ff, cur_in;
   logic [31:0]         prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [SegBits-1:0]  prev_seg_ff, prev_seg_in;
   logic [UBits-1:0]    prev_u_ff, prev_u_in;
   logic                have_prev_ff, have_prev_in;
   logic                exact_ff, exact_in;
   logic [31:0]         min_dist_ff, min_dist_in;
   rec_type             best_ff, best_in;
   logic [32:0]         dx_ff, dx_in, dy_ff, dy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [65:0]         len2_ff, len2_in, dot_ff, dot_in, crabs_ff, crabs_in;
   logic [IterQW-1:0]   den_ff, den_in;
   logic [31:0]         dp_ff, dp_in;
   logic [UBits-1:0]    u2_ff, u2_in;
   logic [UBits-1:0]    t_ff, t_in;
   logic [31:0]         lx_ff, lx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   mac_ctl_type                mac_ctl;
   logic signed [MacAccW-1:0]  mac_acc;
   logic                       mac_done;
   iter_ctl_type               iter_ctl;
   logic [IterQW-1:0]          iter_q;
   logic                       iter_done;

   logic                       req_take;
   logic [MacAccW-1:0]         acc_mag;
   logic [31:0]                root_sat;
   logic [31:0]                lerp_off;

   cpp_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .acc    (mac_acc),
      .done   (mac_done)
   );

   cpp_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (iter_ctl),
      .result (iter_q),
      .done   (iter_done)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   // Helpers on the shared unit results.
   assign acc_mag  = mac_acc[MacAccW-1] ? MacAccW'(-mac_acc) : MacAccW'(mac_acc);
   assign root_sat = (iter_q[IterQW-1:32] != '0) ? DIST_INF : iter_q[31:0];
   assign lerp_off = 32'(mac_acc >>> FracBits);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff <= 32'h0;
         query_y_ff <= 32'h0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_QUERY_X: query_x_ff <= csr_wr_data;
            CSR_QUERY_Y: query_y_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Sequencer over the shared units.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_seg_in  = prev_seg_ff;
      prev_u_in    = prev_u_ff;
      have_prev_in = have_prev_ff;
      exact_in     = exact_ff;
      min_dist_in  = min_dist_ff;
      best_in      = best_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      len2_in      = len2_ff;
      dot_in       = dot_ff;
      crabs_in     = crabs_ff;
      den_in       = den_ff;
      dp_in        = dp_ff;
      u2_in        = u2_ff;
      t_in         = t_ff;
      lx_in        = lx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mac_ctl      = '0;
      iter_ctl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cur_in   = req_data;
               state_in = (!exact_ff && have_prev_ff) ? S_DIFF : S_UPD;
            end
         end
         S_DIFF: begin
            dx_in    = {query_x_ff[31], query_x_ff} - {prev_x_ff[31], prev_x_ff};
            dy_in    = {query_y_ff[31], query_y_ff} - {prev_y_ff[31], prev_y_ff};
            ex_in    = {cur_ff.pos_x[31], cur_ff.pos_x} - {prev_x_ff[31], prev_x_ff};
            ey_in    = {cur_ff.pos_y[31], cur_ff.pos_y} - {prev_y_ff[31], prev_y_ff};
            state_in = S_HIT;
         end
         S_HIT: begin
            if (dx_ff == '0 && dy_ff == '0) begin
               // Query sits on the first sample of the pair: exact hit.
               best_in     = '{seg: prev_seg_ff, u1: prev_u_ff, u2: '0, t: '0, lerp: 1'b0,
                               x: prev_x_ff, y: prev_y_ff};
               min_dist_in = 32'h0;
               exact_in    = 1'b1;
               state_in    = S_UPD;
            end else begin
               mac_ctl  = '{start: 1'b1, sub: 1'b0, a1: {ex_ff[32], ex_ff},
                            b1: {ex_ff[32], ex_ff}, a2: {ey_ff[32], ey_ff},
                            b2: {ey_ff[32], ey_ff}};
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            if (mac_done) begin
               len2_in = mac_acc[65:0];
               if (mac_acc == '0) begin
                  state_in = S_UPD;
               end else begin
                  mac_ctl  = '{start: 1'b1, sub: 1'b0, a1: {ex_ff[32], ex_ff},
                               b1: {dx_ff[32], dx_ff}, a2: {ey_ff[32], ey_ff},
                               b2: {dy_ff[32], dy_ff}};
                  state_in = S_DOT;
               end
            end
         end
         S_DOT: begin
            if (mac_done) begin
               dot_in = mac_acc[65:0];
               if (!mac_acc[MacAccW-1] && (mac_acc <= $signed({2'b00, len2_ff}))) begin
                  // Projection inside the span.
                  mac_ctl  = '{start: 1'b1, sub: 1'b1, a1: {ex_ff[32], ex_ff},
                               b1: {dy_ff[32], dy_ff}, a2: {ey_ff[32], ey_ff},
                               b2: {dx_ff[32], dx_ff}};
                  state_in = S_CR;
               end else if (mac_acc[MacAccW-1]) begin
                  // Projection before the first sample.
                  mac_ctl  = '{start: 1'b1, sub: 1'b0, a1: {dx_ff[32], dx_ff},
                               b1: {dx_ff[32], dx_ff}, a2: {dy_ff[32], dy_ff},
                               b2: {dy_ff[32], dy_ff}};
                  state_in = S_PSM;
               end else begin
                  state_in = S_UPD;
               end
            end
         end
         S_PSM: begin
            if (mac_done) begin
               iter_ctl = '{start: 1'b1, mode_sqrt: 1'b1, steps: PT_STEPS, rem_init: '0,
                            num_init: {mac_acc[65:0], 32'h0}, divisor: '0};
               state_in = S_PSQ;
            end
         end
         S_PSQ: begin
            if (iter_done) begin
               if (root_sat < min_dist_ff) begin
                  best_in     = '{seg: prev_seg_ff, u1: prev_u_ff, u2: '0, t: '0,
                                  lerp: 1'b0, x: prev_x_ff, y: prev_y_ff};
                  min_dist_in = root_sat;
               end
               state_in = S_UPD;
            end
         end
         S_CR: begin
            if (mac_done) begin
               crabs_in = acc_mag[65:0];
               iter_ctl = '{start: 1'b1, mode_sqrt: 1'b1, steps: DEN_STEPS, rem_init: '0,
                            num_init: {len2_ff, 32'h0}, divisor: '0};
               state_in = S_DEN;
            end
         end
         S_DEN: begin
            if (iter_done) begin
               den_in   = iter_q;
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            // A quotient of 2^32 or more saturates; otherwise 32 quotient bits remain.
            if (crabs_ff[65:16] >= {1'b0, den_ff}) begin
               dp_in    = DIST_INF;
               state_in = S_CMP;
            end else begin
               iter_ctl = '{start: 1'b1, mode_sqrt: 1'b0, steps: DP_STEPS,
                            rem_init: {18'h0, crabs_ff[65:16]},
                            num_init: {crabs_ff[15:0], 16'h0, 66'h0},
                            divisor: {17'h0, den_ff}};
               state_in = S_DPD;
            end
         end
         S_DPD: begin
            if (iter_done) begin
               dp_in    = iter_q[31:0];
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (dp_ff >= min_dist_ff) begin
               state_in = S_UPD;
            end else if (prev_seg_ff == cur_ff.seg_index ||
                         (({1'b0, prev_seg_ff} + (SegBits+1)'(1)) ==
                          {1'b0, cur_ff.seg_index} && cur_ff.seg_param == '0)) begin
               u2_in    = (prev_seg_ff == cur_ff.seg_index) ? cur_ff.seg_param : U_ONE;
               iter_ctl = '{start: 1'b1, mode_sqrt: 1'b0, steps: T_STEPS,
                            rem_init: {3'h0, dot_ff[65:1]},
                            num_init: {dot_ff[0], 16'h0, 81'h0},
                            divisor: len2_ff};
               state_in = S_TDV;
            end else begin
               state_in = S_UPD;
            end
         end
         S_TDV: begin
            if (iter_done) begin
               t_in     = iter_q[UBits-1:0];
               mac_ctl  = '{start: 1'b1, sub: 1'b0, a1: {ex_ff[32], ex_ff},
                            b1: {(MacOpW-UBits)'(0), iter_q[UBits-1:0]}, a2: '0, b2: '0};
               state_in = S_LX;
            end
         end
         S_LX: begin
            if (mac_done) begin
               lx_in    = prev_x_ff + lerp_off;
               mac_ctl  = '{start: 1'b1, sub: 1'b0, a1: {ey_ff[32], ey_ff},
                            b1: {(MacOpW-UBits)'(0), t_ff}, a2: '0, b2: '0};
               state_in = S_LY;
            end
         end
         S_LY: begin
            if (mac_done) begin
               best_in     = '{seg: prev_seg_ff, u1: prev_u_ff, u2: u2_ff, t: t_ff,
                               lerp: 1'b1, x: lx_ff, y: prev_y_ff + lerp_off};
               min_dist_in = dp_ff;
               if (dp_ff == 32'h0) begin
                  exact_in = 1'b1;
               end
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            if (!exact_ff) begin
               prev_x_in    = cur_ff.pos_x;
               prev_y_in    = cur_ff.pos_y;
               prev_seg_in  = cur_ff.seg_index;
               prev_u_in    = cur_ff.seg_param;
               have_prev_in = 1'b1;
            end
            state_in = cur_ff.last ? (exact_ff ? S_EMIT : S_FDIF) : S_IDLE;
         end
         S_FDIF: begin
            dx_in    = {query_x_ff[31], query_x_ff} - {cur_ff.pos_x[31], cur_ff.pos_x};
            dy_in    = {query_y_ff[31], query_y_ff} - {cur_ff.pos_y[31], cur_ff.pos_y};
            state_in = S_FMAC;
         end
         S_FMAC: begin
            mac_ctl  = '{start: 1'b1, sub: 1'b0, a1: {dx_ff[32], dx_ff},
                         b1: {dx_ff[32], dx_ff}, a2: {dy_ff[32], dy_ff},
                         b2: {dy_ff[32], dy_ff}};
            state_in = S_FPSM;
         end
         S_FPSM: begin
            if (mac_done) begin
               iter_ctl = '{start: 1'b1, mode_sqrt: 1'b1, steps: PT_STEPS, rem_init: '0,
                            num_init: {mac_acc[65:0], 32'h0}, divisor: '0};
               state_in = S_FPSQ;
            end
         end
         S_FPSQ: begin
            if (iter_done) begin
               if (root_sat < min_dist_ff) begin
                  best_in     = '{seg: cur_ff.seg_index, u1: cur_ff.seg_param, u2: '0,
                                  t: '0, lerp: 1'b0, x: cur_ff.pos_x, y: cur_ff.pos_y};
                  min_dist_in = root_sat;
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // Wait for the output register, then hand over and clear the stream state.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{best_segment: best_ff.seg, best_u1: best_ff.u1,
                                best_u2: best_ff.u2, best_t: best_ff.t,
                                is_lerped: best_ff.lerp, near_x: best_ff.x,
                                near_y: best_ff.y, near_dist: min_dist_ff};
               prev_x_in    = 32'h0;
               prev_y_in    = 32'h0;
               prev_seg_in  = '0;
               prev_u_in    = '0;
               have_prev_in = 1'b0;
               exact_in     = 1'b0;
               min_dist_in  = DIST_INF;
               best_in      = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prev_x_ff    <= 32'h0;
         prev_y_ff    <= 32'h0;
         prev_seg_ff  <= '0;
         prev_u_ff    <= '0;
         have_prev_ff <= 1'b0;
         exact_ff     <= 1'b0;
         min_dist_ff  <= DIST_INF;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         prev_seg_ff  <= prev_seg_in;
         prev_u_ff    <= prev_u_in;
         have_prev_ff <= have_prev_in;
         exact_ff     <= exact_in;
         min_dist_ff  <= min_dist_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff   <= cur_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      len2_ff  <= len2_in;
      dot_ff   <= dot_in;
      crabs_ff <= crabs_in;
      den_ff   <= den_in;
      dp_ff    <= dp_in;
      u2_ff    <= u2_in;
      t_ff     <= t_in;
      lx_ff    <= lx_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // An accepted sample always starts work on the next cycle.
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff != S_IDLE))
      else $error("accepted sample did not start processing");

   // A response with no winner carries no lerp, a zero factor and a zero x coordinate.
   a_inf_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.near_dist == DIST_INF) |->
      (rsp_data.is_lerped == 1'b0 && rsp_data.best_t == '0 && rsp_data.near_x == '0))
      else $error("saturated distance with a nonzero location");

   // A lerped location never has a factor above one, and a point location has none.
   a_lerp_t: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_lerped ? (rsp_data.best_t <= U_ONE)
                                        : (rsp_data.best_t == '0 && rsp_data.best_u2 == '0)))
      else $error("lerp factor inconsistent with location kind");

endmodule

[bench/closest_point_on_polyline_tb.sv]
// Testbench for the polyline nearest-point block: directed cases, random polylines, flow control.
`timescale 1ns / 1ps

module closest_point_on_polyline_tb;
   import cpp_pkg::*;

   typedef logic signed [127:0] s128_type;
   typedef logic [127:0]        u128_type;

   localparam int IdleLimit = 6000;
   localparam int DrainPause = 200;
   localparam logic [63:0] Inf64 = 64'h0000_0000_FFFF_FFFF;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [0:0] csr_index = CSR_QUERY_X;
   logic [31:0] csr_wr_data = '0;

   // Tracker copy of the query point and of the running search.
   logic signed [31:0] query_x = '0, query_y = '0;
   longint      trk_prev_x, trk_prev_y;
   logic [15:0] trk_prev_seg;
   logic [16:0] trk_prev_u;
   bit          trk_have_prev, trk_exact;
   logic [63:0] trk_min;
   rsp_type     trk_best;

   rsp_type expected_q[$];
   int  mismatches = 0;
   int  items_sent = 0;
   int  hold_left = 0;
   bit  calm = 0;
   int  idle_cycles = 0;

   closest_point_on_polyline dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Integer square root, floored, of a 128-bit value.
   function automatic logic [63:0] isqrt(u128_type n);
      logic [63:0] r, c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (u128_type'(c) * u128_type'(c) <= n) r = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] point_dist(longint dx, longint dy);
      s128_type s;
      logic [63:0] r;
      s = s128_type'(dx) * s128_type'(dx) + s128_type'(dy) * s128_type'(dy);
      r = isqrt(u128_type'(s));
      return (r > Inf64) ? Inf64 : r;
   endfunction

   task automatic take_point(longint x, longint y, logic [15:0] seg, logic [16:0] u,
                             logic [63:0] d);
      trk_best = '0;
      trk_best.best_segment = seg;
      trk_best.best_u1 = u;
      trk_best.near_x = x[31:0];
      trk_best.near_y = y[31:0];
      trk_min = d;
   endtask

   task automatic clear_search();
      trk_prev_x = 0;
      trk_prev_y = 0;
      trk_prev_seg = '0;
      trk_prev_u = '0;
      trk_have_prev = 0;
      trk_exact = 0;
      trk_min = Inf64;
      trk_best = '0;
   endtask

   // Scores the span from the held sample to the new one.
   task automatic score_span(longint x2, longint y2, logic [15:0] seg2, logic [16:0] u2in);
      longint dx, dy, ex, ey;
      s128_type len2, dot, cr;
      u128_type q;
      logic [63:0] dpt, dp, den, t;
      logic [16:0] u2;
      bit ok;
      dx = longint'(query_x) - trk_prev_x;
      dy = longint'(query_y) - trk_prev_y;
      ex = x2 - trk_prev_x;
      ey = y2 - trk_prev_y;
      if (dx == 0 && dy == 0) begin
         take_point(trk_prev_x, trk_prev_y, trk_prev_seg, trk_prev_u, 0);
         trk_exact = 1;
         return;
      end
      dpt = point_dist(dx, dy);
      len2 = s128_type'(ex) * s128_type'(ex) + s128_type'(ey) * s128_type'(ey);
      if (len2 == 0) return;
      dot = s128_type'(ex) * s128_type'(dx) + s128_type'(ey) * s128_type'(dy);
      if (dot >= 0 && len2 >= dot) begin
         cr = s128_type'(ex) * s128_type'(dy) - s128_type'(ey) * s128_type'(dx);
         if (cr < 0) cr = -cr;
         den = isqrt(u128_type'(len2) << 32);
         q = (u128_type'(cr) << 16) / u128_type'(den);
         dp = (q > u128_type'(Inf64)) ? Inf64 : q[63:0];
         if (dp >= trk_min) return;
         ok = 1;
         if (trk_prev_seg == seg2) u2 = u2in;
         else if (32'(trk_prev_seg) + 1 == 32'(seg2) && u2in == 0) u2 = U_ONE;
         else begin
            ok = 0;
            u2 = '0;
         end
         if (ok) begin
            q = (u128_type'(dot) << FracBits) / u128_type'(len2);
            t = q[63:0];
            trk_best.best_segment = trk_prev_seg;
            trk_best.best_u1 = trk_prev_u;
            trk_best.best_u2 = u2;
            trk_best.best_t = t[16:0];
            trk_best.is_lerped = 1'b1;
            trk_best.near_x = 32'(trk_prev_x + ((ex * longint'(t)) >>> FracBits));
            trk_best.near_y = 32'(trk_prev_y + ((ey * longint'(t)) >>> FracBits));
            trk_min = dp;
            if (dp == 0) trk_exact = 1;
         end
      end else if (dot < 0 && dpt < trk_min) begin
         take_point(trk_prev_x, trk_prev_y, trk_prev_seg, trk_prev_u, dpt);
      end
   endtask

   // Advances the tracker by one sample; queues the answer at a last sample.
   task automatic track_sample(req_type s);
      longint x, y;
      logic [63:0] d;
      rsp_type r;
      x = longint'(s.pos_x);
      y = longint'(s.pos_y);
      if (!trk_exact && trk_have_prev) score_span(x, y, s.seg_index, s.seg_param);
      if (!trk_exact) begin
         trk_prev_x = x;
         trk_prev_y = y;
         trk_prev_seg = s.seg_index;
         trk_prev_u = s.seg_param;
         trk_have_prev = 1;
      end
      if (!s.last) return;
      if (!trk_exact) begin
         d = point_dist(longint'(query_x) - x, longint'(query_y) - y);
         if (d < trk_min) take_point(x, y, s.seg_index, s.seg_param, d);
      end
      r = trk_best;
      r.near_dist = trk_min[31:0];
      expected_q.push_back(r);
      clear_search();
   endtask

   // Sends one sample; entered and left at a falling edge with valid still high.
   task automatic send_sample(logic [31:0] x, logic [31:0] y, logic [15:0] seg,
                              logic [16:0] u, logic last);
      req_type s;
      s.pos_x = x;
      s.pos_y = y;
      s.seg_index = seg;
      s.seg_param = u;
      s.last = last;
      if (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (req_stall);
      track_sample(s);
      items_sent++;
      @(negedge clock);
   endtask

   // Lowers valid and waits until every expected answer has arrived.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (DrainPause) @(negedge clock);
   endtask

   task automatic set_query(logic [31:0] x, logic [31:0] y);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_QUERY_X;
      csr_wr_data <= x;
      @(negedge clock);
      csr_index <= CSR_QUERY_Y;
      csr_wr_data <= y;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      query_x = x;
      query_y = y;
   endtask

   function automatic logic [31:0] fx(int v);
      return 32'(v) << 16;
   endfunction

   task automatic test_single_sample();
      set_query(fx(3), fx(-4));
      send_sample(fx(0), fx(0), 16'd9, 17'd100, 1'b1);
   endtask

   task automatic test_exact_at_sample();
      set_query(fx(5), fx(3));
      send_sample(fx(5), fx(3), 16'd2, 17'd0, 1'b0);
      send_sample(fx(9), fx(9), 16'd2, 17'd30000, 1'b0);
      send_sample(fx(1), fx(1), 16'd3, 17'd0, 1'b1);
   endtask

   task automatic test_exact_on_span();
      set_query(32'h0, 32'h0);
      send_sample(fx(-1), fx(0), 16'd0, 17'h8000, 1'b0);
      send_sample(fx(1), fx(0), 16'd1, 17'd0, 1'b0);
      send_sample(fx(3), fx(3), 16'd1, 17'd500, 1'b1);
   endtask

   task automatic test_before_span();
      send_sample(fx(2), fx(0), 16'd4, 17'd0, 1'b0);
      send_sample(fx(5), fx(0), 16'd4, 17'd40000, 1'b0);
      send_sample(fx(5), fx(5), 16'd5, 17'd0, 1'b1);
   endtask

   // Projection past the far end, then a span of zero length.
   task automatic test_beyond_and_zero_length();
      set_query(fx(1), fx(2));
      send_sample(fx(-5), fx(0), 16'd7, 17'd0, 1'b0);
      send_sample(fx(-3), fx(0), 16'd7, 17'd9000, 1'b0);
      send_sample(fx(-3), fx(0), 16'd7, 17'd9000, 1'b0);
      send_sample(fx(4), fx(7), 16'd8, 17'd0, 1'b1);
   endtask

   // Non-consecutive indices, no wrap past the top index, u beyond one.
   task automatic test_segment_pairing();
      send_sample(fx(-1), fx(1), 16'd3, 17'd0, 1'b0);
      send_sample(fx(1), fx(1), 16'd7, 17'd0, 1'b1);
      send_sample(fx(-2), fx(3), 16'hFFFF, 17'h1FFFF, 1'b0);
      send_sample(fx(2), fx(3), 16'h0000, 17'd0, 1'b0);
      send_sample(fx(3), fx(4), 16'h0000, 17'h1FFFF, 1'b1);
   endtask

   // Extreme coordinates; nothing wins in the first polyline, the last point wins in the second.
   task automatic test_saturation();
      set_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'h8000_0000, 32'h8000_0000, 16'hFFFF, U_ONE, 1'b0);
      send_sample(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, U_ONE, 1'b1);
      set_query(32'h8000_0000, 32'h8000_0000);
      send_sample(32'h7FFF_FFFF, 32'h8000_0001, 16'h0, 17'd0, 1'b0);
      send_sample(32'h8000_0001, 32'h8000_0000, 16'h0, 17'h1_0000, 1'b1);
   endtask

   // One polyline of n samples with random content around the query point.
   task automatic send_polyline(int n);
      logic [31:0] x, y, px, py;
      logic [15:0] seg;
      logic [16:0] u;
      int span, pick;
      span = 1 << $urandom_range(4, 30);
      seg = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(40));
      u = '0;
      px = query_x;
      py = query_y;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            x = query_x;
            y = query_y;
         end else if (pick < 8) begin
            x = px;
            y = py;
         end else if (pick < 13) begin
            x = $urandom;
            y = $urandom;
         end else begin
            x = query_x + 32'($urandom_range(2 * span) - span);
            y = query_y + 32'($urandom_range(2 * span) - span);
         end
         if (k > 0) begin
            pick = $urandom_range(99);
            if (pick < 45) u = (u < 17'd60000) ? u + 17'($urandom_range(1, 5000)) : u;
            else if (pick < 90) begin
               seg = seg + 16'd1;
               u = '0;
            end else begin
               seg = $urandom;
               u = $urandom_range(17'h1FFFF);
            end
         end
         send_sample(x, y, seg, u, k == n - 1);
         px = x;
         py = y;
      end
   endtask

   task automatic test_random_polylines();
      int batch;
      batch = 0;
      while (items_sent < 1000) begin
         if (batch % 8 == 0) begin
            if ($urandom_range(3) == 0) set_query($urandom, $urandom);
            else set_query(32'($urandom_range(2000000) - 1000000),
                           32'($urandom_range(2000000) - 1000000));
         end
         calm = (batch >= 30 && batch < 45);
         send_polyline($urandom_range(1, 12));
         batch++;
      end
      calm = 0;
   endtask

   // Receiver holds off while polylines keep coming, so the block backs up.
   task automatic test_backpressure();
      hold_left = 1500;
      repeat (4) send_polyline($urandom_range(2, 6));
      wait_idle();
   endtask

   // Sender pauses until every answer is in, then resumes.
   task automatic test_drain_pause();
      send_polyline(5);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      send_polyline(4);
   endtask

   // Receiver stall: long hold-offs on request, else random idling.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 11);
      end
   end

   function automatic bit fields_differ(rsp_type a, rsp_type b);
      return a.best_segment !== b.best_segment || a.best_u1 !== b.best_u1 ||
             a.best_u2 !== b.best_u2 || a.best_t !== b.best_t ||
             a.is_lerped !== b.is_lerped || a.near_x !== b.near_x ||
             a.near_y !== b.near_y || a.near_dist !== b.near_dist;
   endfunction

   // Each answer transaction is checked against the oldest expectation.
   always @(posedge clock) begin : answer_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected answer %p", rsp_data);
         end else begin
            want = expected_q.pop_front();
            if (fields_differ(want, rsp_data)) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("closest_point_on_polyline_tb failed");
         $finish;
      end
   end

   initial begin
      clear_search();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_single_sample();
      test_exact_at_sample();
      test_exact_on_span();
      test_before_span();
      test_beyond_and_zero_length();
      test_segment_pairing();
      test_saturation();
      test_backpressure();
      test_drain_pause();
      test_random_polylines();
      wait_idle();
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("closest_point_on_polyline_tb passed");
      end else begin
         $display("closest_point_on_polyline_tb failed");
      end
      $finish;
   end

endmodule
